[design/vtp_pkg.sv]
// Package for the vertex transform unit: payload words, queue entry and divider stage types.
// Used by every module of the block; depends on nothing.
package vtp_pkg;

	localparam int unsigned CoordW   = 32;
	localparam int unsigned ElemW    = 16;
	localparam int unsigned RowW     = 64;
	localparam int unsigned SumW     = 50;
	localparam int unsigned MagW     = 49;
	localparam int unsigned FracW    = 16;
	localparam int unsigned NumRows  = 4;
	localparam int unsigned NumLanes = 3;
	localparam int unsigned DivSteps = 32;

	localparam logic [RowW-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
	localparam logic [RowW-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
	localparam logic [RowW-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
	localparam logic [RowW-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

	localparam logic [CoordW-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [CoordW-1:0] Q_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		REG_ROW0 = 2'd0,
		REG_ROW1 = 2'd1,
		REG_ROW2 = 2'd2,
		REG_ROW3 = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic signed [CoordW-1:0] in_x;
		logic signed [CoordW-1:0] in_y;
		logic signed [CoordW-1:0] in_z;
	} vtx_word_t;

	typedef struct packed {
		logic signed [CoordW-1:0] out_x;
		logic signed [CoordW-1:0] out_y;
		logic signed [CoordW-1:0] out_z;
		logic                     w_was_zero;
		logic                     saturated;
	} res_word_t;

	// One coordinate as classified by the front end.
	typedef struct packed {
		logic [MagW-1:0]   un;
		logic              neg;
		logic              ovf;
		logic [CoordW-1:0] und;
		logic              und_sat;
	} q_lane_t;

	typedef struct packed {
		logic [MagW-1:0]          ud;
		logic                     wz;
		q_lane_t [NumLanes-1:0]   lane;
	} q_entry_t;

	// One coordinate inside the divider pipeline.
	typedef struct packed {
		logic [MagW-1:0]   rem;
		logic [FracW-1:0]  nlo;
		logic [CoordW-1:0] quo;
		logic              neg;
		logic              ovf;
		logic [CoordW-1:0] und;
		logic              und_sat;
	} div_lane_t;

	typedef struct packed {
		logic [MagW-1:0]          ud;
		logic                     wz;
		div_lane_t [NumLanes-1:0] lane;
	} div_stage_t;

	// Queue status seen by the two sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// One restoring division step: bring in the next dividend bit and
	// subtract the divisor when it fits.
	function automatic div_lane_t div_step(div_lane_t l, logic [MagW-1:0] d);
		logic [MagW:0] r2;
		logic [MagW:0] diff;
		logic          ge;
		div_lane_t     o;
		o    = l;
		r2   = {l.rem, l.nlo[FracW-1]};
		diff = r2 - {1'b0, d};
		ge   = ~diff[MagW];
		o.rem = ge ? diff[MagW-1:0] : r2[MagW-1:0];
		o.nlo = {l.nlo[FracW-2:0], 1'b0};
		o.quo = {l.quo[CoordW-2:0], ge};
		return o;
	endfunction

endpackage

[design/vertex_transform_perspective_unit.sv]
// Top level of the vertex transform unit with perspective divide.
// Instantiates vtp_front, vtp_queue and vtp_back; depends on vtp_pkg.

// This unit takes one vertex word (x, y, z in signed Q16.16) per cycle and
// multiplies (x, y, z, 1) by a 4x4 matrix of signed Q4.12 elements held in
// four 64-bit row registers, which reset to the identity. The fourth row gives
// w. When w is nonzero each coordinate is divided by w and rounded toward zero;
// when w is zero the undivided coordinate is returned, rounded toward minus
// infinity, and w_was_zero is set. Any coordinate outside the Q16.16 range is
// clamped and raises saturated. A sustained rate of one vertex per cycle is
// kept while neither vtx_stall nor res_stall holds the flow: the front end
// registers products, partial row sums, row sums and the classified entry, a
// queue of QUEUE_DEPTH words decouples it from the back end, and the back end
// registers the queue head, runs a 32-stage restoring divider (one quotient
// bit per stage for all three coordinates) and ends in an output register.
// Matrix rows are written through cfg_we, cfg_index and cfg_data and must only
// change while no vertex is in flight.
module vertex_transform_perspective_unit import vtp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [RowW-1:0] cfg_data,
	input  logic            vtx_valid,
	output logic            vtx_stall,
	input  vtx_word_t       vtx,
	output logic            res_valid,
	input  logic            res_stall,
	output res_word_t       res
);

	q_status_t qstat;
	q_entry_t  q_wr, q_rd;
	logic      q_push, q_pop;

	// Front end: takes vertices and classifies them into queue entries.
	vtp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.qstat     (qstat),
		.push      (q_push),
		.entry     (q_wr)
	);

	vtp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.status  (qstat)
	);

	// Back end: divides and delivers result words.
	vtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_rd),
		.qstat     (qstat),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

[design/vtp_front.sv]
// Front end of the vertex transform: matrix registers, products, row sums and classification.
// Depends on vtp_pkg.
module vtp_front import vtp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [RowW-1:0] cfg_data,
	input  logic            vtx_valid,
	output logic            vtx_stall,
	input  vtx_word_t       vtx,
	input  q_status_t       qstat,
	output logic            push,
	output q_entry_t        entry
);

	logic [RowW-1:0] row_q [NumRows];

	logic                       valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [2*CoordW-17:0] prod_s1 [NumRows][NumLanes];
	logic signed [SumW-1:0]     pa_s2 [NumRows];
	logic signed [SumW-1:0]     pb_s2 [NumRows];
	logic signed [SumW-1:0]     sum_s3 [NumRows];
	q_entry_t                   entry_s4;

	logic adv;
	logic signed [CoordW-1:0] coord [NumLanes];
	logic signed [ElemW-1:0]  elem [NumRows][NumRows];
	q_entry_t                 cls;
	logic signed [SumW-1:0]   sw_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RESET;
			row_q[1] <= ROW1_RESET;
			row_q[2] <= ROW2_RESET;
			row_q[3] <= ROW3_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ROW0: row_q[0] <= cfg_data;
				REG_ROW1: row_q[1] <= cfg_data;
				REG_ROW2: row_q[2] <= cfg_data;
				REG_ROW3: row_q[3] <= cfg_data;
				default:  row_q[0] <= row_q[0];
			endcase
		end
	end

	assign adv       = !(valid_s4 && qstat.full);
	assign vtx_stall = !adv;
	assign push      = valid_s4 && !qstat.full;
	assign entry     = entry_s4;

	always_comb begin
		coord[0] = vtx.in_x;
		coord[1] = vtx.in_y;
		coord[2] = vtx.in_z;
		for (int r = 0; r < NumRows; r++) begin
			for (int k = 0; k < NumRows; k++) begin
				elem[r][k] = row_q[r][k*ElemW +: ElemW];
			end
		end
	end

	// Classification: zero w test, magnitudes, signs, quotient range check and
	// the undivided result used when w is zero.
	always_comb begin
		logic signed [SumW-13:0] sh;
		logic [MagW-1:0]         un;
		sw_abs = sum_s3[3][SumW-1] ? -sum_s3[3] : sum_s3[3];
		cls.ud = sw_abs[MagW-1:0];
		cls.wz = (sum_s3[3] == '0);
		for (int l = 0; l < NumLanes; l++) begin
			un = sum_s3[l][SumW-1] ? MagW'(-sum_s3[l]) : MagW'(sum_s3[l]);
			cls.lane[l].un  = un;
			cls.lane[l].neg = sum_s3[l][SumW-1] ^ sum_s3[3][SumW-1];
			cls.lane[l].ovf = {{FracW{1'b0}}, un[MagW-1:FracW]} >= cls.ud;
			sh = sum_s3[l][SumW-1:12];
			if (sh[SumW-13:CoordW-1] == '0 || sh[SumW-13:CoordW-1] == '1) begin
				cls.lane[l].und     = sh[CoordW-1:0];
				cls.lane[l].und_sat = 1'b0;
			end else begin
				cls.lane[l].und     = sh[SumW-13] ? Q_MIN : Q_MAX;
				cls.lane[l].und_sat = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= vtx_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < NumRows; r++) begin
				for (int c = 0; c < NumLanes; c++) begin
					prod_s1[r][c] <= elem[r][c] * coord[c];
				end
				pa_s2[r] <= SumW'(prod_s1[r][0]) + SumW'(prod_s1[r][1]);
				pb_s2[r] <= SumW'(prod_s1[r][2])
					+ SumW'($signed({elem[r][3], {FracW{1'b0}}}));
				sum_s3[r] <= pa_s2[r] + pb_s2[r];
			end
			entry_s4 <= cls;
		end
	end

endmodule

[design/vtp_queue.sv]
// Short queue between the front end and the divider back end.
// Depends on vtp_pkg.
module vtp_queue import vtp_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  wr_data,
	input  logic      pop,
	output q_entry_t  rd_data,
	output q_status_t status
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign status.full  = (count_q == CntW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntW'(DEPTH))
		else $error("queue count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) status.full |-> !push)
		else $error("push into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) status.empty |-> !pop)
		else $error("pop from an empty queue");

endmodule

[design/vtp_back.sv]
// Back end of the vertex transform: pipelined restoring divider, final saturation, output register.
// Depends on vtp_pkg.
module vtp_back import vtp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_entry_t  head,
	input  q_status_t qstat,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res
);

	logic       valid_s [DivSteps+1];
	div_stage_t div_s [DivSteps+1];
	logic       res_valid_q;
	res_word_t  res_q;

	logic       adv;
	div_stage_t init;
	res_word_t  fin;

	assign adv       = !res_valid_q || !res_stall;
	assign pop       = adv && !qstat.empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		init.ud = head.ud;
		init.wz = head.wz;
		for (int l = 0; l < NumLanes; l++) begin
			init.lane[l].rem     = {{FracW{1'b0}}, head.lane[l].un[MagW-1:FracW]};
			init.lane[l].nlo     = head.lane[l].un[FracW-1:0];
			init.lane[l].quo     = '0;
			init.lane[l].neg     = head.lane[l].neg;
			init.lane[l].ovf     = head.lane[l].ovf;
			init.lane[l].und     = head.lane[l].und;
			init.lane[l].und_sat = head.lane[l].und_sat;
		end
	end

	// Sign and range of each quotient, or the undivided value when w is zero.
	always_comb begin
		logic [CoordW-1:0]    val [NumLanes];
		logic [NumLanes-1:0]  sat;
		div_lane_t            ln;
		for (int l = 0; l < NumLanes; l++) begin
			ln = div_s[DivSteps].lane[l];
			if (div_s[DivSteps].wz) begin
				val[l] = ln.und;
				sat[l] = ln.und_sat;
			end else if (ln.ovf) begin
				val[l] = ln.neg ? Q_MIN : Q_MAX;
				sat[l] = 1'b1;
			end else if (ln.neg) begin
				sat[l] = ln.quo > Q_MIN;
				val[l] = sat[l] ? Q_MIN : -ln.quo;
			end else begin
				sat[l] = ln.quo[CoordW-1];
				val[l] = sat[l] ? Q_MAX : ln.quo;
			end
		end
		fin.out_x      = val[0];
		fin.out_y      = val[1];
		fin.out_z      = val[2];
		fin.w_was_zero = div_s[DivSteps].wz;
		fin.saturated  = |sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= DivSteps; s++) begin
				valid_s[s] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= !qstat.empty;
			for (int s = 1; s <= DivSteps; s++) begin
				valid_s[s] <= valid_s[s-1];
			end
			res_valid_q <= valid_s[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= init;
			for (int s = 1; s <= DivSteps; s++) begin
				div_s[s].ud <= div_s[s-1].ud;
				div_s[s].wz <= div_s[s-1].wz;
				for (int l = 0; l < NumLanes; l++) begin
					div_s[s].lane[l] <= div_step(div_s[s-1].lane[l], div_s[s-1].ud);
				end
			end
			res_q <= fin;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> $stable(valid_s[DivSteps]))
		else $error("divider moved while frozen");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.w_was_zero && res.saturated) |->
		(res.out_x == Q_MAX || res.out_x == Q_MIN || res.out_y == Q_MAX ||
		 res.out_y == Q_MIN || res.out_z == Q_MAX || res.out_z == Q_MIN))
		else $error("saturation flagged without a clamped coordinate");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for vertex_transform_perspective_unit: matrix transform and w divide.
// Depends on vtp_pkg and the unit; a local predictor or a typed word checks every result word.

module testbench;
	import vtp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 60;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [1:0]      cfg_index;
	logic [RowW-1:0] cfg_data;
	logic            vtx_valid;
	logic            vtx_stall;
	vtx_word_t       vtx;
	logic            res_valid;
	logic            res_stall;
	res_word_t       res;

	vertex_transform_perspective_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// The predictor keeps its own copy of the four matrix rows.
	logic [RowW-1:0] mat_rows [NumRows];
	res_word_t       pending_results [$];
	int              mismatches;
	int              results_seen;
	int              words_sent;
	int              wz_seen;
	int              sat_seen;
	int              idle_cycles;
	bit              hold_receiver;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Row sum of (x, y, z, 1) in Q.28; magnitude stays below 2^48.
	function automatic longint row_dot(logic [RowW-1:0] r, longint x, longint y, longint z);
		longint e0, e1, e2, e3;
		e0 = longint'($signed(r[15:0]));
		e1 = longint'($signed(r[31:16]));
		e2 = longint'($signed(r[47:32]));
		e3 = longint'($signed(r[63:48]));
		return e0 * x + e1 * y + e2 * z + e3 * 65536;
	endfunction

	// Undivided Q.28 sum to Q16.16 by floor, then clamp.
	function automatic logic [31:0] floor_clamp(longint n, inout bit sat);
		longint v;
		v = n >>> 12;
		if (v > 64'sd2147483647) begin
			sat = 1;
			return Q_MAX;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	// Quotient n / d in Q16.16, truncated toward zero, saturating.
	function automatic logic [31:0] divide_w(longint n, longint d, inout bit sat);
		bit              neg;
		longint unsigned un, ud, q, r, f, mag;
		neg = (n < 0) != (d < 0);
		un  = n < 0 ? -n : n;
		ud  = d < 0 ? -d : d;
		q   = un / ud;
		r   = un % ud;
		f   = 0;
		if (q > 64'h8000) q = 64'h8001;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			f = f << 1;
			if (r >= ud) begin
				r = r - ud;
				f = f | 1;
			end
		end
		mag = (q << 16) | f;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				sat = 1;
				return Q_MIN;
			end
			return 32'(-longint'(mag));
		end
		if (mag > 64'h7FFF_FFFF) begin
			sat = 1;
			return Q_MAX;
		end
		return mag[31:0];
	endfunction

	function automatic res_word_t transform_vertex(vtx_word_t v);
		longint    x, y, z, sx, sy, sz, sw;
		bit        sat;
		res_word_t o;
		x  = longint'(v.in_x);
		y  = longint'(v.in_y);
		z  = longint'(v.in_z);
		sx = row_dot(mat_rows[REG_ROW0], x, y, z);
		sy = row_dot(mat_rows[REG_ROW1], x, y, z);
		sz = row_dot(mat_rows[REG_ROW2], x, y, z);
		sw = row_dot(mat_rows[REG_ROW3], x, y, z);
		sat = 0;
		o.w_was_zero = (sw == 0);
		if (sw == 0) begin
			o.out_x = floor_clamp(sx, sat);
			o.out_y = floor_clamp(sy, sat);
			o.out_z = floor_clamp(sz, sat);
		end else begin
			o.out_x = divide_w(sx, sw, sat);
			o.out_y = divide_w(sy, sw, sat);
			o.out_z = divide_w(sz, sw, sat);
		end
		o.saturated = sat;
		return o;
	endfunction

	// Writes one matrix row in the unit and in the predictor.
	task automatic write_row(reg_index_t idx, logic [RowW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mat_rows[idx] = val;
	endtask

	task automatic load_matrix(logic [RowW-1:0] r0, logic [RowW-1:0] r1,
			logic [RowW-1:0] r2, logic [RowW-1:0] r3);
		write_row(REG_ROW0, r0);
		write_row(REG_ROW1, r1);
		write_row(REG_ROW2, r2);
		write_row(REG_ROW3, r3);
		@(posedge clk);
	endtask

	// Offers one vertex word and returns after the edge that accepts it.
	// Valid stays high after acceptance so that the next word can follow
	// with no gap; an idle gap or the drain drops it.
	// An optional expected word replaces the predictor for directed rows.
	task automatic send_vertex(vtx_word_t v, bit use_typed, res_word_t typed, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx       <= v;
		do @(posedge clk); while (vtx_stall);
		pending_results.push_back(use_typed ? typed : transform_vertex(v));
		words_sent++;
	endtask

	task automatic wait_drained();
		vtx_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000);
			2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			default: return 32'($urandom_range(0, 8)) << 16;
		endcase
	endfunction

	function automatic logic [15:0] rand_elem(int mode);
		case (mode)
			0: return 16'($urandom());
			1: return 16'($signed(13'($urandom())) - 16'sd4096);
			2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			default: return 16'($urandom_range(0, 3)) << 12;
		endcase
	endfunction

	function automatic logic [RowW-1:0] rand_row(int mode);
		return {rand_elem(mode), rand_elem(mode), rand_elem(mode), rand_elem(mode)};
	endfunction

	// Receiver: random stalls, plus a long hold-off while hold_receiver is set.
	initial begin
		int wait_cycles;
		res_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_receiver) begin
				res_stall <= 1'b1;
				repeat (200) @(posedge clk);
				hold_receiver = 0;
			end
			wait_cycles = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) wait_cycles = 0;
			if (wait_cycles != 0) begin
				res_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	// Result checker: every accepted word is compared with the oldest expectation.
	always @(posedge clk) begin
		res_word_t exp_w;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", res);
			end else begin
				exp_w = pending_results.pop_front();
				if (exp_w.w_was_zero) wz_seen++;
				if (exp_w.saturated) sat_seen++;
				if (res !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: x %h/%h y %h/%h z %h/%h wz %b/%b sat %b/%b",
							exp_w.out_x, res.out_x, exp_w.out_y, res.out_y,
							exp_w.out_z, res.out_z, exp_w.w_was_zero, res.w_was_zero,
							exp_w.saturated, res.saturated);
				end
			end
		end
	end

	// Watchdog on cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((vtx_valid && !vtx_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress, %0d results pending", pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	typedef struct {
		vtx_word_t v;
		bit        typed;
		res_word_t r;
	} dir_row_t;

	initial begin
		dir_row_t  dir_rows [$];
		vtx_word_t v;
		int        mode;
		mismatches    = 0;
		results_seen  = 0;
		words_sent    = 0;
		wz_seen       = 0;
		sat_seen      = 0;
		idle_cycles   = 0;
		hold_receiver = 0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_ROW0;
		cfg_data  = '0;
		vtx_valid = 1'b0;
		vtx       = '0;
		mat_rows[REG_ROW0] = ROW0_RESET;
		mat_rows[REG_ROW1] = ROW1_RESET;
		mat_rows[REG_ROW2] = ROW2_RESET;
		mat_rows[REG_ROW3] = ROW3_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity after reset: the output repeats the input, extremes included.
		dir_rows.push_back('{'{32'sd0, 32'sd0, 32'sd0}, 1, '{0, 0, 0, 0, 0}});
		dir_rows.push_back('{'{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000}, 1,
			'{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 0, 0}});
		dir_rows.push_back('{'{32'shFFFFFFFF, 32'sh00000001, 32'sh80000000}, 1,
			'{32'shFFFFFFFF, 32'sh00000001, 32'sh80000000, 0, 0}});
		dir_rows.push_back('{'{32'sh12345678, 32'shEDCBA987, 32'sh55555555}, 0, '0});
		foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].r, 0);
		wait_drained();

		// Zero w: row 3 all zero, so coordinates pass undivided and the flag rises.
		load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, '0);
		dir_rows.delete();
		dir_rows.push_back('{'{32'sh00030000, 32'shFFFF8000, 32'sh7FFFFFFF}, 1,
			'{32'sh00030000, 32'shFFFF8000, 32'sh7FFFFFFF, 1, 0}});
		dir_rows.push_back('{'{32'sh80000000, 32'sh00000000, 32'shFFFFFFFF}, 1,
			'{32'sh80000000, 32'sh00000000, 32'shFFFFFFFF, 1, 0}});
		foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].r, 0);
		wait_drained();

		// Extreme elements with row 3 zero: saturation of the undivided path.
		load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
			64'h7FFF_8000_7FFF_8000, '0);
		dir_rows.delete();
		dir_rows.push_back('{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 1,
			'{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 1, 1}});
		dir_rows.push_back('{'{32'sh80000000, 32'sh80000000, 32'sh80000000}, 0, '0});
		dir_rows.push_back('{'{32'sh00000000, 32'sh00000000, 32'sh00000000}, 0, '0});
		foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].r, 0);
		wait_drained();

		// Tiny nonzero w makes quotients overflow; negative w flips signs.
		load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
			64'h0000_0000_0000_1000, 64'h0000_0000_0000_0001);
		dir_rows.delete();
		dir_rows.push_back('{'{32'sh00000001, 32'sh00010000, 32'sh80000000}, 0, '0});
		dir_rows.push_back('{'{32'shFFFFFFFF, 32'sh7FFFFFFF, 32'sh00000000}, 0, '0});
		dir_rows.push_back('{'{32'sh00000000, 32'sh00000000, 32'sh00000000}, 0, '0});
		foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].r, 0);
		wait_drained();
		load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
			64'h0000_1000_0000_0000, 64'hF000_0000_0000_0000);
		send_vertex('{32'sh00050000, 32'sh80000000, 32'sh00000001}, 0, '0, 0);
		send_vertex('{32'sh7FFFFFFF, 32'shFFFFFFFF, 32'sh00000000}, 0, '0, 0);
		wait_drained();

		// Back pressure: the receiver holds off while words keep coming back to back.
		hold_receiver = 1;
		for (int i = 0; i < 60; i++) begin
			v = '{rand_coord(0), rand_coord(1), rand_coord(2)};
			send_vertex(v, 0, '0, 1);
		end
		wait_drained();

		// Random phases: a new matrix per phase, several coordinate styles.
		for (int phase = 0; phase < 20; phase++) begin
			mode = $urandom_range(0, 3);
			if (phase % 5 == 0)
				load_matrix(rand_row(mode), rand_row(mode), rand_row(mode),
					{rand_elem(mode), 48'h0});
			else
				load_matrix(rand_row(mode), rand_row(mode), rand_row(mode),
					rand_row($urandom_range(0, 3)));
			for (int i = 0; i < 50; i++) begin
				v = '{rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
					rand_coord($urandom_range(0, 3))};
				send_vertex(v, 0, '0, 0);
			end
			// The sender pauses until every result has come before the next matrix.
			wait_drained();
		end

		$display("Sent %0d vertex words over 25 matrix settings; %0d results checked.",
			words_sent, results_seen);
		$display("Zero-w results: %0d, saturated results: %0d.", wz_seen, sat_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[filelist.f]
design/vtp_pkg.sv
design/vtp_front.sv
design/vtp_queue.sv
design/vtp_back.sv
design/vertex_transform_perspective_unit.sv
verif/testbench.sv
